FILE: rtl/core/isospi_read_session_checker_top_macros.svh
// assertion macros for the isospi read-session checker
// used by isospi_read_session_checker_top; no other dependencies
`ifndef ISOSPI_READ_SESSION_CHECKER_TOP_MACROS_SVH
`define ISOSPI_READ_SESSION_CHECKER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ISRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ISRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/isrc_pkg.sv
// shared types, constants and pec functions for the isospi read-session checker
// no dependencies
`default_nettype none

package isrc_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IO       = 3'd1,
        ST_CLOCK    = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_PEC      = 3'd4,
        ST_COUNTER  = 3'd5,
        ST_IDENTITY = 3'd6
    } t_status;

    localparam logic        OP_WAKE      = 1'b0;
    localparam logic        OP_READ      = 1'b1;
    localparam logic        KIND_SID     = 1'b0;
    localparam logic [7:0]  OPC_SID      = 8'h2C;
    localparam logic [7:0]  OPC_CFGA     = 8'h02;
    localparam logic [5:0]  SID_IDENT    = 6'd3;
    localparam logic [23:0] GUARD_RESET  = 24'd4000;
    localparam logic [15:0] PEC15_SEED   = 16'h0010;
    localparam logic [15:0] PEC15_POLY   = 16'h4599;
    localparam logic [15:0] PEC10_SEED   = 16'h0010;
    localparam logic [15:0] PEC10_POLY   = 16'h008F;

    typedef struct packed {
        logic        session_ok;
        logic [63:0] last_time_us;
        logic [5:0]  last_counter;
        logic        counter_known;
    } t_state;

    typedef struct packed {
        logic        op;
        logic        cold;
        logic        kind;
        logic        guarded;
        logic [1:0]  io_fail;
        logic [2:0]  clock_fail;
        logic [63:0] time_first_us;
        logic [63:0] time_wake_us;
        logic [63:0] time_after_us;
        logic [63:0] rx_frame;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] command_word;
        logic [47:0] sample_data;
        logic [5:0]  sample_counter;
        logic        sample_valid;
    } t_result;

    localparam t_state STATE_CLEAR = '{session_ok: 1'b0, last_time_us: 64'd0,
                                       last_counter: 6'd0, counter_known: 1'b0};

    // pec15 over the bytes 0x00 and opcode, shifted left by one
    function automatic logic [15:0] crc15_cmd(input logic [7:0] opcode);
        logic [15:0] r;
        logic [7:0]  byte_v;
        r = PEC15_SEED;
        for (int i = 0; i < 2; i++) begin
            byte_v = (i == 0) ? 8'h00 : opcode;
            r = r ^ ({8'h00, byte_v} << 7);
            for (int b = 0; b < 8; b++) begin
                r = (r << 1) ^ (r[14] ? PEC15_POLY : 16'h0000);
            end
        end
        return {r[14:0], 1'b0};
    endfunction

    // pec10 over response bytes 0..5, then the 6-bit counter
    function automatic logic [9:0] crc10_resp(input logic [63:0] frame,
                                              input logic [5:0]  counter);
        logic [15:0] r;
        logic [7:0]  byte_v;
        r = PEC10_SEED;
        for (int i = 0; i < 6; i++) begin
            byte_v = frame[63 - 8 * i -: 8];
            r = r ^ ({8'h00, byte_v} << 2);
            for (int b = 0; b < 8; b++) begin
                r = (r << 1) ^ (r[9] ? PEC10_POLY : 16'h0000);
            end
        end
        r = r ^ {6'd0, counter, 4'd0};
        for (int b = 0; b < 6; b++) begin
            r = (r << 1) ^ (r[9] ? PEC10_POLY : 16'h0000);
        end
        return r[9:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/isrc_step.sv
// transaction evaluation: guard check, command build, pec10, counter and identity checks
// depends on isrc_pkg
`default_nettype none

module isrc_step (
    input  wire isrc_pkg::t_item   i_item,
    input  wire isrc_pkg::t_state  i_state,
    input  wire [23:0]             i_guard_us,
    output isrc_pkg::t_state       o_state,
    output isrc_pkg::t_result      o_result
);
    import isrc_pkg::*;

    logic [64:0] age;
    logic        expired;
    logic [7:0]  opcode;
    logic [31:0] cmd;
    logic [5:0]  rx_counter;
    logic        pec_bad;
    logic        ident_bad;

    assign age        = {1'b0, i_item.time_first_us} - {1'b0, i_state.last_time_us};
    // borrow out means time went backwards
    assign expired    = !i_state.session_ok || age[64] ||
                        (age[63:0] >= {40'd0, i_guard_us});
    assign opcode     = (i_item.kind == KIND_SID) ? OPC_SID : OPC_CFGA;
    assign cmd        = {8'h00, opcode, crc15_cmd(opcode)};
    assign rx_counter = i_item.rx_frame[15:10];
    assign pec_bad    = i_item.rx_frame[9:0] != crc10_resp(i_item.rx_frame, rx_counter);
    assign ident_bad  = (i_item.kind == KIND_SID) && (i_item.rx_frame[54:49] != SID_IDENT);

    always_comb begin
        t_state  cur;
        logic    stop;
        logic    mismatch;
        cur      = i_state;
        stop     = 1'b0;
        mismatch = 1'b0;
        o_result = '{status: ST_OK, command_word: 32'd0, sample_data: 48'd0,
                     sample_counter: 6'd0, sample_valid: 1'b0};
        if (i_item.op == OP_WAKE) begin
            cur = STATE_CLEAR;
            if (i_item.io_fail[0]) begin
                o_result.status = ST_IO;
            end else if (i_item.clock_fail[1]) begin
                o_result.status = ST_CLOCK;
            end else begin
                cur.last_time_us = i_item.time_wake_us;
                cur.session_ok   = !i_item.cold;
            end
        end else if (i_item.clock_fail[0]) begin
            cur             = STATE_CLEAR;
            o_result.status = ST_CLOCK;
        end else begin
            if (expired) begin
                cur = STATE_CLEAR;
                if (i_item.guarded) begin
                    o_result.status = ST_EXPIRED;
                    stop            = 1'b1;
                end else if (i_item.io_fail[0]) begin
                    o_result.status = ST_IO;
                    stop            = 1'b1;
                end else if (i_item.clock_fail[1]) begin
                    o_result.status = ST_CLOCK;
                    stop            = 1'b1;
                end else begin
                    // warm re-wake of the link
                    cur.last_time_us = i_item.time_wake_us;
                    cur.session_ok   = 1'b1;
                end
            end
            if (!stop) begin
                o_result.command_word = cmd;
                if (i_item.io_fail[1]) begin
                    cur             = STATE_CLEAR;
                    o_result.status = ST_IO;
                end else if (i_item.clock_fail[2] ||
                             (i_item.time_after_us < cur.last_time_us)) begin
                    cur             = STATE_CLEAR;
                    o_result.status = ST_CLOCK;
                end else if (pec_bad) begin
                    cur             = STATE_CLEAR;
                    o_result.status = ST_PEC;
                end else begin
                    mismatch          = cur.counter_known && (cur.last_counter != rx_counter);
                    cur.last_time_us  = i_item.time_after_us;
                    cur.last_counter  = rx_counter;
                    cur.counter_known = 1'b1;
                    if (mismatch) begin
                        o_result.status = ST_COUNTER;
                    end else if (ident_bad) begin
                        o_result.status = ST_IDENTITY;
                    end else begin
                        o_result.sample_data    = i_item.rx_frame[63:16];
                        o_result.sample_counter = rx_counter;
                        o_result.sample_valid   = 1'b1;
                    end
                end
            end
        end
        o_state = cur;
    end

endmodule

`default_nettype wire

FILE: rtl/core/isospi_read_session_checker_top.sv
// isospi read-session checker: top level with item register, session state and result register
// depends on isrc_pkg, isrc_step and isospi_read_session_checker_top_macros.svh
//
// usage
//   input channel: i_in_valid / o_in_stall, one wake or read transaction per item with
//   the callback outcomes (fail flags, three timestamps, received 8-byte frame)
//   output channel: o_out_valid / i_out_stall, one result item per input item
//   config: i_cfg_we / i_cfg_data writes the 24-bit guard time in microseconds
//   order: the item register loads at the accepting edge and the result register when
//   the item advances, which a stalled result ahead of it can hold back; the session
//   state is updated at the same edge as the result register, so the next item sees it
//   throughput: one item per cycle while the output is not stalled; the limit is the
//   single pass from item to result register (65-bit age subtract and 64-bit compare)
//   stall: while a result waits, one further item is held in the item register and
//   o_in_stall rises only when that register is also full
//   reset: synchronous, active low; the session is invalid, last time and counter
//   are zero, the guard returns to 4000 us and both registers are empty
`default_nettype none

module isospi_read_session_checker_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [23:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_op,
    input  wire         i_cold,
    input  wire         i_kind,
    input  wire         i_guarded,
    input  wire  [1:0]  i_io_fail,
    input  wire  [2:0]  i_clock_fail,
    input  wire  [63:0] i_time_first_us,
    input  wire  [63:0] i_time_wake_us,
    input  wire  [63:0] i_time_after_us,
    input  wire  [63:0] i_rx_frame,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_command_word,
    output logic [47:0] o_sample_data,
    output logic [5:0]  o_sample_counter,
    output logic        o_sample_valid
);
    import isrc_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;
    logic    [23:0] r_guard_us;
    logic    advance;
    logic    in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    isrc_step u_step (
        .i_item     (r_item),
        .i_state    (r_state),
        .i_guard_us (r_guard_us),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_us <= GUARD_RESET;
        end else if (i_cfg_we) begin
            r_guard_us <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= '{op: i_op, cold: i_cold, kind: i_kind, guarded: i_guarded,
                        io_fail: i_io_fail, clock_fail: i_clock_fail,
                        time_first_us: i_time_first_us, time_wake_us: i_time_wake_us,
                        time_after_us: i_time_after_us, rx_frame: i_rx_frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_command_word   = r_result.command_word;
    assign o_sample_data    = r_result.sample_data;
    assign o_sample_counter = r_result.sample_counter;
    assign o_sample_valid   = r_result.sample_valid;

`include "isospi_read_session_checker_top_macros.svh"

    `ISRC_ASSERT_NOW(a_sample_ok, i_clk, i_rst_n, o_out_valid && o_sample_valid,
        o_status == ST_OK, "sample valid without ok status")
    `ISRC_ASSERT_NOW(a_sample_zero, i_clk, i_rst_n, o_out_valid && !o_sample_valid,
        (o_sample_data == 48'd0) && (o_sample_counter == 6'd0), "sample fields not cleared")
    `ISRC_ASSERT_NOW(a_expired_nocmd, i_clk, i_rst_n, o_out_valid && (o_status == ST_EXPIRED),
        o_command_word == 32'd0, "command built on expired session")
    `ISRC_ASSERT_NEXT(a_held_item, i_clk, i_rst_n, r_in_valid && r_out_valid && i_out_stall,
        r_in_valid && r_out_valid, "item lost while output stalled")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for isospi_read_session_checker_top: directed rows, then random
// transactions checked against a local session predictor; depends on isrc_pkg and the rtl top
module tb_top;
    import isrc_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          LONG_HOLD   = 240;
    localparam logic        KIND_CFG    = ~KIND_SID;
    localparam logic [14:0] POLY15      = 15'h4599;
    localparam logic [9:0]  POLY10      = 10'h08F;
    localparam logic [63:0] ALL_ONES    = {64{1'b1}};

    typedef struct {
        t_item   it;
        bit      fixed;
        t_status status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = 1'b0;
    logic        i_cold = 1'b0;
    logic        i_kind = 1'b0;
    logic        i_guarded = 1'b0;
    logic [1:0]  i_io_fail = '0;
    logic [2:0]  i_clock_fail = '0;
    logic [63:0] i_time_first_us = '0;
    logic [63:0] i_time_wake_us = '0;
    logic [63:0] i_time_after_us = '0;
    logic [63:0] i_rx_frame = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_command_word;
    logic [47:0] o_sample_data;
    logic [5:0]  o_sample_counter;
    logic        o_sample_valid;

    t_state      sess;
    logic [23:0] guard_now;
    t_result     result_q[$];
    t_stim_row   dir_rows[$];
    int          errors = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;
    bit          holding = 1'b0;
    event        long_hold_ev;

    always #1 i_clk = ~i_clk;

    isospi_read_session_checker_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_cold           (i_cold),
        .i_kind           (i_kind),
        .i_guarded        (i_guarded),
        .i_io_fail        (i_io_fail),
        .i_clock_fail     (i_clock_fail),
        .i_time_first_us  (i_time_first_us),
        .i_time_wake_us   (i_time_wake_us),
        .i_time_after_us  (i_time_after_us),
        .i_rx_frame       (i_rx_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_command_word   (o_command_word),
        .o_sample_data    (o_sample_data),
        .o_sample_counter (o_sample_counter),
        .o_sample_valid   (o_sample_valid)
    );

    // bit-serial pec15 over 0x00 and the opcode, msb first
    function automatic logic [15:0] cmd_pec15(input logic [7:0] opcode);
        logic [14:0] rem;
        logic [15:0] msg;
        logic        fb;
        rem = 15'd16;
        msg = {8'h00, opcode};
        for (int k = 15; k >= 0; k--) begin
            fb  = rem[14] ^ msg[k];
            rem = {rem[13:0], 1'b0} ^ (fb ? POLY15 : 15'h0);
        end
        return {rem, 1'b0};
    endfunction

    // bit-serial pec10 over response bytes 0..5 followed by the counter
    function automatic logic [9:0] resp_pec10(input logic [47:0] data, input logic [5:0] cnt);
        logic [9:0]  rem;
        logic [53:0] msg;
        logic        fb;
        rem = 10'd16;
        msg = {data, cnt};
        for (int k = 53; k >= 0; k--) begin
            fb  = rem[9] ^ msg[k];
            rem = {rem[8:0], 1'b0} ^ (fb ? POLY10 : 10'h0);
        end
        return rem;
    endfunction

    function automatic logic [63:0] make_frame(input logic [47:0] data, input logic [5:0] cnt);
        return {data, cnt, resp_pec10(data, cnt)};
    endfunction

    // identity field sits in byte 1 bits 6:1
    function automatic logic [47:0] sid_data(input logic [47:0] d);
        return {d[47:39], SID_IDENT, d[32:0]};
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_status wake_link(input logic cold, input t_item it);
        sess = STATE_CLEAR;
        if (it.io_fail[0]) return ST_IO;
        if (it.clock_fail[1]) return ST_CLOCK;
        sess.last_time_us = it.time_wake_us;
        sess.session_ok   = ~cold;
        return ST_OK;
    endfunction

    function automatic t_result predict_transaction(input t_item it);
        t_result    res;
        logic [7:0] opc;
        logic [5:0] cnt;
        logic       mismatch;
        res        = '0;
        res.status = ST_OK;
        if (it.op == OP_WAKE) begin
            res.status = wake_link(it.cold, it);
            return res;
        end
        if (it.clock_fail[0]) begin
            sess       = STATE_CLEAR;
            res.status = ST_CLOCK;
            return res;
        end
        if (!sess.session_ok || it.time_first_us < sess.last_time_us ||
            it.time_first_us - sess.last_time_us >= {40'd0, guard_now}) begin
            sess = STATE_CLEAR;
            if (it.guarded) begin
                res.status = ST_EXPIRED;
                return res;
            end
            res.status = wake_link(1'b0, it);
            if (res.status != ST_OK) return res;
        end
        opc = (it.kind == KIND_SID) ? OPC_SID : OPC_CFGA;
        res.command_word = {8'h00, opc, cmd_pec15(opc)};
        if (it.io_fail[1]) begin
            sess       = STATE_CLEAR;
            res.status = ST_IO;
            return res;
        end
        if (it.clock_fail[2] || it.time_after_us < sess.last_time_us) begin
            sess       = STATE_CLEAR;
            res.status = ST_CLOCK;
            return res;
        end
        sess.last_time_us = it.time_after_us;
        cnt = it.rx_frame[15:10];
        if (it.rx_frame[9:0] != resp_pec10(it.rx_frame[63:16], cnt)) begin
            sess       = STATE_CLEAR;
            res.status = ST_PEC;
            return res;
        end
        mismatch           = sess.counter_known && sess.last_counter != cnt;
        sess.last_counter  = cnt;
        sess.counter_known = 1'b1;
        if (mismatch) begin
            res.status = ST_COUNTER;
            return res;
        end
        if (it.kind == KIND_SID && it.rx_frame[54:49] != SID_IDENT) begin
            res.status = ST_IDENTITY;
            return res;
        end
        res.sample_data    = it.rx_frame[63:16];
        res.sample_counter = cnt;
        res.sample_valid   = 1'b1;
        return res;
    endfunction

    function automatic t_item mk_item(input logic op, input logic cold, input logic kind,
                                      input logic guarded, input logic [1:0] io,
                                      input logic [2:0] clk_f, input logic [63:0] tf,
                                      input logic [63:0] tw, input logic [63:0] ta,
                                      input logic [63:0] frame);
        t_item it;
        it.op            = op;
        it.cold          = cold;
        it.kind          = kind;
        it.guarded       = guarded;
        it.io_fail       = io;
        it.clock_fail    = clk_f;
        it.time_first_us = tf;
        it.time_wake_us  = tw;
        it.time_after_us = ta;
        it.rx_frame      = frame;
        return it;
    endfunction

    // mostly well-formed reads that follow the predicted session, some wakes, some noise
    function automatic t_item random_item();
        t_item       it;
        logic [63:0] age;
        logic [47:0] data;
        logic [5:0]  cnt;
        int unsigned pick;
        int          k;
        pick             = $urandom_range(0, 99);
        it.op            = 1'($urandom);
        it.cold          = 1'($urandom);
        it.kind          = 1'($urandom);
        it.guarded       = 1'($urandom);
        it.io_fail       = 2'($urandom);
        it.clock_fail    = 3'($urandom);
        it.time_first_us = rnd64();
        it.time_wake_us  = rnd64();
        it.time_after_us = rnd64();
        it.rx_frame      = rnd64();
        if (pick < 12) return it;
        if (pick < 24) begin
            it.op   = OP_WAKE;
            it.cold = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) != 0) begin
                it.io_fail    = '0;
                it.clock_fail = '0;
            end
            if ($urandom_range(0, 5) != 0)
                it.time_wake_us = sess.last_time_us + 64'($urandom_range(0, 5000));
            return it;
        end
        it.op      = OP_READ;
        it.guarded = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 19) != 0) it.io_fail = '0;
        if ($urandom_range(0, 19) != 0) it.clock_fail = '0;
        case ($urandom_range(0, 19))
            0: begin
                age = {40'd0, guard_now} + 64'($urandom_range(0, 100));
            end
            1: begin
                age = 64'd0 - 64'($urandom_range(1, 1000));
            end
            2: begin
                age = {40'd0, guard_now} - 64'd1;
            end
            default: begin
                age = (guard_now == 0) ? 64'd0 : 64'($urandom_range(0, guard_now - 1));
            end
        endcase
        it.time_first_us = sess.last_time_us + age;
        it.time_wake_us  = it.time_first_us + 64'($urandom_range(0, 50));
        if ($urandom_range(0, 29) == 0)
            it.time_after_us = it.time_wake_us - 64'($urandom_range(1, 100));
        else
            it.time_after_us = it.time_wake_us + 64'($urandom_range(0, 500));
        cnt = (sess.counter_known && $urandom_range(0, 9) != 0) ? sess.last_counter
                                                                : 6'($urandom);
        data[47:32] = 16'($urandom);
        data[31:0]  = $urandom;
        if (it.kind == KIND_SID && $urandom_range(0, 9) != 0) data = sid_data(data);
        it.rx_frame = make_frame(data, cnt);
        if ($urandom_range(0, 12) == 0) begin
            k = $urandom_range(0, 63);
            it.rx_frame[k] = ~it.rx_frame[k];
        end
        return it;
    endfunction

    task automatic add_row(input t_item it, input bit fixed, input t_status st);
        t_stim_row r;
        r.it     = it;
        r.fixed  = fixed;
        r.status = st;
        dir_rows.push_back(r);
    endtask

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= it.op;
        i_cold          <= it.cold;
        i_kind          <= it.kind;
        i_guarded       <= it.guarded;
        i_io_fail       <= it.io_fail;
        i_clock_fail    <= it.clock_fail;
        i_time_first_us <= it.time_first_us;
        i_time_wake_us  <= it.time_wake_us;
        i_time_after_us <= it.time_after_us;
        i_rx_frame      <= it.rx_frame;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic run_item(input t_item it);
        result_q.push_back(predict_transaction(it));
        send_item(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_guard(input logic [23:0] g);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= g;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        guard_now  = g;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // long receiver hold, counted here so the sender keeps offering items meanwhile
    initial begin : long_hold_proc
        forever begin
            @(long_hold_ev);
            @(posedge i_clk);
            holding = 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            holding = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (holding) begin
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 12);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t ns: result expected none, got status %0d", $time, o_status);
            end else begin
                want = result_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("command_word", want.command_word, o_command_word);
                check_field("sample_data", want.sample_data, o_sample_data);
                check_field("sample_counter", want.sample_counter, o_sample_counter);
                check_field("sample_valid", want.sample_valid, o_sample_valid);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_result want;
        sess      = STATE_CLEAR;
        guard_now = GUARD_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, failure paths, cold wake, counter and identity checks, time extremes
        add_row(mk_item(OP_READ, 0, KIND_SID, 1, 2'b00, 3'b000, 100, 100, 100, 0),
                1, ST_EXPIRED);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 0, 2'b00, 3'b001, 100, 100, 100, 0),
                1, ST_CLOCK);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b01, 3'b000, 0, 1000, 0, 0), 1, ST_IO);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b010, 0, 1000, 0, 0), 1, ST_CLOCK);
        add_row(mk_item(OP_WAKE, 1, KIND_SID, 0, 2'b00, 3'b000, 0, 1000, 0, 0), 1, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 1, 2'b00, 3'b000, 1010, 1010, 1010, 0),
                1, ST_EXPIRED);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0, 1000, 0, 0), 1, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 1, 2'b00, 3'b000, 1100, 1100, 1200,
                        make_frame(sid_data(48'h0123_4567_89AB), 6'd5)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 1300, 1300, 1400,
                        make_frame(48'hFEDC_BA98_7654, 6'd5)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 1500, 1500, 1600,
                        make_frame(48'h5A5A_A5A5_3C3C, 6'd9)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 1, 2'b00, 3'b000, 1700, 1700, 1800,
                        make_frame(48'h0, 6'd9)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 1900, 1900, 2000,
                        make_frame(48'h1111_2222_3333, 6'd9) ^ 64'h1), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 0, 2'b00, 3'b000, 2100, 2150, 2200,
                        make_frame(sid_data(48'h0123_4567_89AB), 6'd5)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b10, 3'b000, 2300, 2300, 2400,
                        make_frame(48'h0, 6'd5)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 0, 2'b01, 3'b000, 2500, 2500, 2600, 0),
                1, ST_IO);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0,
                        64'hFFFF_FFFF_FFFF_F000, 0, 0), 1, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 64'hFFFF_FFFF_FFFF_F800,
                        64'hFFFF_FFFF_FFFF_F800, ALL_ONES,
                        make_frame(48'hFFFF_FFFF_FFFF, 6'h3F)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_SID, 1, 2'b00, 3'b000, 5, 5, 5, 0), 1, ST_EXPIRED);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0, 5000, 0, 0), 1, ST_OK);
        // post-read time earlier than the wake time
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 5000, 5000, 4000,
                        make_frame(48'h0, 6'd1)), 0, ST_OK);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0, 5000, 0, 0), 1, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b100, 5000, 5000, 6000,
                        make_frame(48'h0, 6'd1)), 0, ST_OK);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0, 0, 0, 0), 1, ST_OK);
        // age one below the guard, then exactly the guard
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 3999, 3999, 3999,
                        make_frame(48'h8000_0000_0001, 6'd1)), 0, ST_OK);
        add_row(mk_item(OP_READ, 0, KIND_CFG, 1, 2'b00, 3'b000, 7999, 7999, 7999, 0),
                1, ST_EXPIRED);
        add_row(mk_item(OP_READ, 1, KIND_CFG, 1, 2'b11, 3'b111, ALL_ONES, ALL_ONES, ALL_ONES,
                        ALL_ONES), 1, ST_CLOCK);
        add_row(mk_item(OP_WAKE, 0, KIND_SID, 0, 2'b00, 3'b000, 0, 0, 0, 0), 1, ST_OK);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].fixed) begin
                void'(predict_transaction(dir_rows[n].it));
                want        = '0;
                want.status = dir_rows[n].status;
                result_q.push_back(want);
                send_item(dir_rows[n].it);
            end else begin
                run_item(dir_rows[n].it);
            end
        end

        repeat (150) run_item(random_item());
        set_guard(24'd1);
        repeat (80) run_item(random_item());
        set_guard(24'hFF_FFFF);
        repeat (150) run_item(random_item());
        set_guard(24'd0);
        repeat (40) run_item(random_item());
        set_guard(24'($urandom_range(1, 24'hFF_FFFF)));

        // receiver holds off until the block backs up into its input
        drain();
        -> long_hold_ev;
        repeat (30) run_item(random_item());
        repeat (100) run_item(random_item());

        idle_on = 1'b0;
        set_guard(24'($urandom_range(50, 20000)));
        repeat (120) run_item(random_item());

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
